// ===== rtl/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg
// shared codes and the control bundle handed to every list cell
// ----------------------------------------------------------------------------
package ple_pkg;

  // request opcodes
  localparam logic [1:0] OP_INS  = 2'd0;
  localparam logic [1:0] OP_DEL  = 2'd1;
  localparam logic [1:0] OP_DISP = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  // cell commands
  localparam logic [1:0] CMD_HOLD = 2'd0;
  localparam logic [1:0] CMD_INS  = 2'd1;
  localparam logic [1:0] CMD_DEL  = 2'd2;
  localparam logic [1:0] CMD_ROT  = 2'd3;

  // index width covering the largest supported list (64 entries)
  localparam int PLE_IDX_W = 6;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [PLE_IDX_W-1:0] sel;   // target slot of an insert or delete
    logic [PLE_IDX_W-1:0] tail;  // last occupied slot, for rotation
  } ple_ctrl_t;

endpackage

// ===== rtl/ple_cell.sv =====
// ----------------------------------------------------------------------------
// ple_cell
// one slot of the list; loads, shifts or rotates by its own position
// ----------------------------------------------------------------------------
module ple_cell import ple_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic        clk,
  input  ple_ctrl_t   ctrl,
  input  logic [31:0] value,
  input  logic [31:0] left,
  input  logic [31:0] right,
  input  logic [31:0] head,
  output logic [31:0] data
);

  localparam logic [PLE_IDX_W-1:0] MY_IDX = PLE_IDX_W'(IDX);

  logic [31:0] data_r;
  logic [31:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctrl.cmd)
      CMD_INS: begin
        if (MY_IDX == ctrl.sel) begin
          data_nxt = value;
        end else if (MY_IDX > ctrl.sel) begin
          data_nxt = left;
        end
      end
      CMD_DEL: begin
        if (MY_IDX >= ctrl.sel) begin
          data_nxt = right;
        end
      end
      CMD_ROT: begin
        // wrap the head into the tail slot
        if (MY_IDX == ctrl.tail) begin
          data_nxt = head;
        end else if (MY_IDX < ctrl.tail) begin
          data_nxt = right;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ===== rtl/positional_list_engine.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine
// ordered list of signed 32-bit values addressed by 1-based position
// ----------------------------------------------------------------------------
// A request is taken at a clock edge with start high and busy low. Insert and
// delete shift the whole row of cells in the cycle they are taken, and the
// single status result shows on the next cycle, while busy stays low, so a
// new request may follow every cycle. A display of n entries holds busy
// while it streams one entry per cycle, first to last, as the row
// rotates through cell 0; an empty display gives one result. Results are
// strobed by out_valid for one cycle each and cannot be held off, so the
// receiver must take every strobe.
// ----------------------------------------------------------------------------
module positional_list_engine import ple_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_opcode,
  input  logic [7:0]         in_position,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_value_out,
  output logic               out_last
);

  localparam int CW = $clog2(CAPACITY + 1);  // entry count
  localparam int IW = $clog2(CAPACITY);      // display index

  // control state
  logic [CW-1:0] count_r, count_nxt;
  logic          disp_r, disp_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          valid_r, valid_nxt;

  // result payload
  logic [1:0]  status_r, status_nxt;
  logic [31:0] value_r, value_nxt;
  logic        last_r, last_nxt;

  // cell row
  ple_ctrl_t   ctrl;
  logic [31:0] cell_q [CAPACITY];

  logic       accept;
  logic [8:0] pos9;
  logic [8:0] cnt9;
  logic       pos_zero;
  logic       ins_range_ok;
  logic       del_range_ok;
  logic       full;
  logic       disp_end;

  assign accept       = start && !busy;
  assign pos9         = {1'b0, in_position};
  assign cnt9         = 9'(count_r);
  assign pos_zero     = (in_position == 8'd0);
  assign ins_range_ok = !pos_zero && (pos9 <= cnt9 + 9'd1);
  assign del_range_ok = !pos_zero && (pos9 <= cnt9);
  assign full         = (count_r == CW'(CAPACITY));
  assign disp_end     = (CW'(idx_r) == count_r - CW'(1));

  always_comb begin
    count_nxt  = count_r;
    disp_nxt   = disp_r;
    idx_nxt    = idx_r;
    valid_nxt  = 1'b0;
    status_nxt = ST_OK;
    value_nxt  = 32'd0;
    last_nxt   = 1'b1;
    ctrl.cmd   = CMD_HOLD;
    // slot of the request, meaningful only for an accepted edit
    ctrl.sel   = PLE_IDX_W'(in_position - 8'd1);
    ctrl.tail  = PLE_IDX_W'(count_r - CW'(1));

    if (disp_r) begin
      // stream the head then rotate the occupied part of the row
      valid_nxt = 1'b1;
      value_nxt = cell_q[0];
      last_nxt  = disp_end;
      ctrl.cmd  = CMD_ROT;
      idx_nxt   = idx_r + IW'(1);
      if (disp_end) begin
        disp_nxt = 1'b0;
      end
    end else if (accept) begin
      unique case (in_opcode)
        OP_INS: begin
          valid_nxt = 1'b1;
          if (!ins_range_ok) begin
            status_nxt = ST_BADPOS;
          end else if (full) begin
            status_nxt = ST_FULL;
          end else begin
            ctrl.cmd  = CMD_INS;
            count_nxt = count_r + CW'(1);
          end
        end
        OP_DEL: begin
          valid_nxt = 1'b1;
          if (!del_range_ok) begin
            status_nxt = ST_BADPOS;
          end else begin
            ctrl.cmd  = CMD_DEL;
            count_nxt = count_r - CW'(1);
          end
        end
        OP_DISP: begin
          if (count_r == '0) begin
            valid_nxt  = 1'b1;
            status_nxt = ST_EMPTY;
          end else begin
            disp_nxt = 1'b1;
            idx_nxt  = '0;
          end
        end
        default: begin
          // unused opcode: no result, no change
        end
      endcase
    end
  end

  // row of cells, each wired to its left and right neighbours
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [31:0] left_d;
    logic [31:0] right_d;
    if (g == 0) begin : g_first
      assign left_d = 32'd0;
    end else begin : g_inner_l
      assign left_d = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign right_d = 32'd0;
    end else begin : g_inner_r
      assign right_d = cell_q[g+1];
    end
    ple_cell #(.IDX(g)) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .value (in_value),
      .left  (left_d),
      .right (right_d),
      .head  (cell_q[0]),
      .data  (cell_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      disp_r  <= 1'b0;
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      disp_r  <= disp_nxt;
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    value_r  <= value_nxt;
    last_r   <= last_nxt;
  end

  assign busy          = disp_r;
  assign out_valid     = valid_r;
  assign out_status    = status_r;
  assign out_value_out = value_r;
  assign out_last      = last_r;

  // an empty display closes its own request
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> out_last)
    else $error("empty status without last");

  // a display only runs over a non-empty list
  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (count_r != '0))
    else $error("display running on empty list");

  // a streamed entry that is not the last is followed by another
  a_stream_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("gap in display stream");

  // the entry count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

endmodule
